>>> sv/llm_pkg.sv
// Shared types, constants and the smoothing function of the load level monitor.
package llm_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int OCC_WIDTH_DEF   = 16;

    // Q1.16 fixed point
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [63:0] ALPHA_Q16 = 64'd21627;
    localparam logic [63:0] KEEP_Q16  = 64'd65536 - 64'd21627;
    localparam logic [63:0] ROUND_Q16 = 64'd32768;

    // handshakes per microsecond to per second
    localparam logic [31:0] US_PER_S = 32'd1000000;

    typedef enum logic [1:0] {
        LVL_NORMAL   = 2'd0,
        LVL_ELEVATED = 2'd1,
        LVL_OVER     = 2'd2
    } t_level;

    typedef enum logic [2:0] {
        CFG_RATE_HIGH    = 3'd0,
        CFG_RATE_LOW     = 3'd1,
        CFG_QUEUE_HIGH   = 3'd2,
        CFG_QUEUE_LOW    = 3'd3,
        CFG_PENDING_HIGH = 3'd4,
        CFG_PENDING_LOW  = 3'd5,
        CFG_RATIO_MIN    = 3'd6,
        CFG_RATIO_LOW    = 3'd7
    } t_cfg_index;

    // divider operation of the sequencer
    typedef enum logic [1:0] {
        OP_QUEUE   = 2'd0,
        OP_PENDING = 2'd1,
        OP_RATE    = 2'd2,
        OP_RATIO   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SMOOTH,
        ST_DELTA,
        ST_MULT,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [15:0] queue_used;
        logic [15:0] queue_size;
        logic [15:0] pending_used;
        logic [15:0] pending_size;
        logic [31:0] received_total;
        logic [31:0] completed_total;
        logic [47:0] time_us;
    } t_sample;

    typedef struct packed {
        logic [1:0]  load_level;
        logic        level_changed;
        logic [31:0] change_count;
        logic [31:0] smoothed_rate;
        logic [16:0] smoothed_queue;
        logic [16:0] smoothed_pending;
        logic [16:0] smoothed_ratio;
    } t_result;

    // new = (prev*(1-alpha) + sample*alpha + 0.5) >> 16
    function automatic logic [31:0] smooth_q(logic [31:0] prev, logic [31:0] sample);
        logic [63:0] acc;
        acc = {32'd0, prev} * KEEP_Q16 + {32'd0, sample} * ALPHA_Q16 + ROUND_Q16;
        return acc[47:16];
    endfunction

endpackage

>>> sv/llm_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
interface llm_in_if;
    logic              valid;
    logic              ready;
    llm_pkg::t_sample  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface llm_out_if;
    logic              valid;
    logic              ready;
    llm_pkg::t_result  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface llm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/load_level_monitor.sv
// Load level monitor: sequencer around one shared restoring divider.
//
// One sample is taken at a time. A sample runs up to four divisions (queue
// fraction, pending fraction, handshake rate, completion ratio) on one shared
// divider that retires one quotient bit per cycle, each division followed by a
// smoothing step. Saturated or zero-capacity divisions skip the divider, and
// the first sample after reset only runs the two fractions. The result sits in
// an output register, so the next sample is taken while it waits. Registers are
// written over their own channel; the user must write them only while the block
// is idle, which the block itself does not enforce.
module load_level_monitor #(
    parameter int COUNT_WIDTH = llm_pkg::COUNT_WIDTH_DEF,
    parameter int OCC_WIDTH   = llm_pkg::OCC_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    llm_in_if.sink         i_in,
    llm_cfg_if.sink        i_cfg,
    llm_out_if.source      o_out
);

    localparam int OW = (OCC_WIDTH < 16) ? OCC_WIDTH : 16;
    localparam int CW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    localparam logic [15:0] OCC_MASK = 16'((64'd1 << OW) - 64'd1);
    localparam logic [31:0] CNT_MASK = 32'((64'd1 << CW) - 64'd1);

    // configuration
    logic [23:0] r_rate_high, r_rate_low;
    logic [16:0] r_queue_high, r_queue_low, r_pending_high, r_pending_low, r_ratio_low;
    logic [31:0] r_ratio_min;

    // sequencer and datapath
    llm_pkg::t_state r_state, n_state;
    llm_pkg::t_op    r_op, n_op;
    llm_pkg::t_sample r_smp, n_smp;
    logic        r_eval, n_eval;
    logic        r_primed, n_primed;
    logic [47:0] r_prev_time, n_prev_time;
    logic [31:0] r_prev_rx, n_prev_rx, r_prev_cx, n_prev_cx;
    logic [31:0] r_dr, n_dr, r_dc, n_dc;
    logic [47:0] r_el, n_el;
    logic [63:0] r_num, n_num;
    logic [47:0] r_den, n_den;
    logic [47:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_sample, n_sample;
    logic [16:0] r_qavg, n_qavg, r_pavg, n_pavg, r_ratavg, n_ratavg;
    logic [31:0] r_ravg, n_ravg;
    llm_pkg::t_level r_level, n_level;
    logic [31:0] r_changes, n_changes;
    logic        r_out_valid, n_out_valid;
    llm_pkg::t_result r_out, n_out;

    // combinational helpers
    logic [63:0] ld_num;
    logic [47:0] ld_den;
    logic        wide;
    logic        sat;
    logic [48:0] trial;
    logic        ge;
    logic [31:0] sm_prev;
    logic [31:0] smoothed;
    logic [31:0] rl_q8, rh_q8;
    logic        susp, high, low;
    llm_pkg::t_level decided;

    assign i_in.ready  = (r_state == llm_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_high    <= 24'd1000;
            r_rate_low     <= 24'd200;
            r_queue_high   <= 17'd52429;
            r_queue_low    <= 17'd19661;
            r_pending_high <= 17'd52429;
            r_pending_low  <= 17'd19661;
            r_ratio_min    <= 32'd16;
            r_ratio_low    <= 17'd32768;
        end else if (i_cfg.valid) begin
            unique case (llm_pkg::t_cfg_index'(i_cfg.index))
                llm_pkg::CFG_RATE_HIGH:    r_rate_high    <= i_cfg.data[23:0];
                llm_pkg::CFG_RATE_LOW:     r_rate_low     <= i_cfg.data[23:0];
                llm_pkg::CFG_QUEUE_HIGH:   r_queue_high   <= i_cfg.data[16:0];
                llm_pkg::CFG_QUEUE_LOW:    r_queue_low    <= i_cfg.data[16:0];
                llm_pkg::CFG_PENDING_HIGH: r_pending_high <= i_cfg.data[16:0];
                llm_pkg::CFG_PENDING_LOW:  r_pending_low  <= i_cfg.data[16:0];
                llm_pkg::CFG_RATIO_MIN:    r_ratio_min    <= i_cfg.data;
                llm_pkg::CFG_RATIO_LOW:    r_ratio_low    <= i_cfg.data[16:0];
                default: ;
            endcase
        end
    end

    // divider operand select per operation
    always_comb begin
        wide = (r_op == llm_pkg::OP_RATE);
        case (r_op)
            llm_pkg::OP_QUEUE: begin
                ld_num = {32'd0, r_smp.queue_used, 16'd0};
                ld_den = {32'd0, r_smp.queue_size};
            end
            llm_pkg::OP_PENDING: begin
                ld_num = {32'd0, r_smp.pending_used, 16'd0};
                ld_den = {32'd0, r_smp.pending_size};
            end
            llm_pkg::OP_RATE: begin
                ld_num = r_num;
                ld_den = r_el;
            end
            default: begin
                ld_num = {16'd0, r_dc, 16'd0};
                ld_den = {16'd0, r_dr};
            end
        endcase
        // quotient would not fit the bits the divider retires
        if (wide) sat = ({16'd0, ld_num[63:32]} >= ld_den);
        else      sat = ({1'b0, ld_num[63:17]} >= ld_den);
    end

    // one divider step
    assign trial = {r_rem, r_num[r_cnt]};
    assign ge    = (trial >= {1'b0, r_den});

    // shared smoother: select the running average, then one smoothing unit
    always_comb begin
        case (r_op)
            llm_pkg::OP_QUEUE:   sm_prev = {15'd0, r_qavg};
            llm_pkg::OP_PENDING: sm_prev = {15'd0, r_pavg};
            llm_pkg::OP_RATE:    sm_prev = r_ravg;
            default:             sm_prev = {15'd0, r_ratavg};
        endcase
        smoothed = llm_pkg::smooth_q(sm_prev, r_sample);
    end

    // level decision with hysteresis
    always_comb begin
        rl_q8 = {r_rate_low, 8'd0};
        rh_q8 = {r_rate_high, 8'd0};
        susp  = (r_ravg >= rl_q8) && (r_ratavg < r_ratio_low);
        high  = (r_ravg >= rh_q8) || (r_qavg >= r_queue_high) || (r_pavg >= r_pending_high);
        low   = (r_ravg <= rl_q8) && (r_qavg <= r_queue_low) && (r_pavg <= r_pending_low);
        if (!r_eval)          decided = r_level;
        else if (high || susp) decided = llm_pkg::LVL_OVER;
        else if (low)          decided = llm_pkg::LVL_NORMAL;
        else if (r_level == llm_pkg::LVL_OVER) decided = llm_pkg::LVL_OVER;
        else                   decided = llm_pkg::LVL_ELEVATED;
    end

    // sequencer: next state and datapath
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_smp       = r_smp;
        n_eval      = r_eval;
        n_primed    = r_primed;
        n_prev_time = r_prev_time;
        n_prev_rx   = r_prev_rx;
        n_prev_cx   = r_prev_cx;
        n_dr        = r_dr;
        n_dc        = r_dc;
        n_el        = r_el;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_sample    = r_sample;
        n_qavg      = r_qavg;
        n_pavg      = r_pavg;
        n_ratavg    = r_ratavg;
        n_ravg      = r_ravg;
        n_level     = r_level;
        n_changes   = r_changes;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;

        unique case (r_state)
            llm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_smp.queue_used      = i_in.data.queue_used & OCC_MASK;
                    n_smp.queue_size      = i_in.data.queue_size & OCC_MASK;
                    n_smp.pending_used    = i_in.data.pending_used & OCC_MASK;
                    n_smp.pending_size    = i_in.data.pending_size & OCC_MASK;
                    n_smp.received_total  = i_in.data.received_total & CNT_MASK;
                    n_smp.completed_total = i_in.data.completed_total & CNT_MASK;
                    n_smp.time_us         = i_in.data.time_us;
                    n_op    = llm_pkg::OP_QUEUE;
                    n_state = llm_pkg::ST_LOAD;
                end
            end
            llm_pkg::ST_LOAD: begin
                n_num = ld_num;
                n_den = ld_den;
                if (ld_den == 48'd0) begin
                    // zero capacity gives 0; zero received gives ratio 1.0
                    n_sample = (r_op == llm_pkg::OP_RATIO) ? {15'd0, llm_pkg::ONE_Q16} : 32'd0;
                    n_state  = llm_pkg::ST_SMOOTH;
                end else if (sat) begin
                    n_sample = wide ? 32'hFFFF_FFFF : {15'd0, llm_pkg::ONE_Q16};
                    n_state  = llm_pkg::ST_SMOOTH;
                end else begin
                    n_rem   = wide ? {16'd0, ld_num[63:32]} : {1'b0, ld_num[63:17]};
                    n_cnt   = wide ? 6'd31 : 6'd16;
                    n_quo   = 32'd0;
                    n_state = llm_pkg::ST_DIV;
                end
            end
            llm_pkg::ST_DIV: begin
                n_rem = ge ? 48'(trial - {1'b0, r_den}) : trial[47:0];
                n_quo = {r_quo[30:0], ge};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_sample = (!wide && (n_quo > {15'd0, llm_pkg::ONE_Q16}))
                             ? {15'd0, llm_pkg::ONE_Q16} : n_quo;
                    n_state  = llm_pkg::ST_SMOOTH;
                end
            end
            llm_pkg::ST_SMOOTH: begin
                case (r_op)
                    llm_pkg::OP_QUEUE: begin
                        n_qavg  = smoothed[16:0];
                        n_op    = llm_pkg::OP_PENDING;
                        n_state = llm_pkg::ST_LOAD;
                    end
                    llm_pkg::OP_PENDING: begin
                        n_pavg = smoothed[16:0];
                        if (!r_primed) begin
                            // first sample only primes the history
                            n_primed    = 1'b1;
                            n_prev_time = r_smp.time_us;
                            n_prev_rx   = r_smp.received_total;
                            n_prev_cx   = r_smp.completed_total;
                            n_eval      = 1'b0;
                            n_state     = llm_pkg::ST_DECIDE;
                        end else begin
                            n_eval  = 1'b1;
                            n_state = llm_pkg::ST_DELTA;
                        end
                    end
                    llm_pkg::OP_RATE: begin
                        n_ravg = smoothed;
                        if (r_dr >= r_ratio_min) begin
                            n_op    = llm_pkg::OP_RATIO;
                            n_state = llm_pkg::ST_LOAD;
                        end else begin
                            n_state = llm_pkg::ST_DECIDE;
                        end
                    end
                    default: begin
                        n_ratavg = smoothed[16:0];
                        n_state  = llm_pkg::ST_DECIDE;
                    end
                endcase
            end
            llm_pkg::ST_DELTA: begin
                if (r_smp.time_us > r_prev_time) begin
                    n_el = r_smp.time_us - r_prev_time;
                    n_dr = (r_smp.received_total >= r_prev_rx)
                         ? r_smp.received_total - r_prev_rx : 32'd0;
                    n_dc = (r_smp.completed_total >= r_prev_cx)
                         ? r_smp.completed_total - r_prev_cx : 32'd0;
                    n_prev_time = r_smp.time_us;
                    n_prev_rx   = r_smp.received_total;
                    n_prev_cx   = r_smp.completed_total;
                    n_state     = llm_pkg::ST_MULT;
                end else begin
                    n_state = llm_pkg::ST_DECIDE;
                end
            end
            llm_pkg::ST_MULT: begin
                // received * 256e6 as (received * 1e6) << 8
                n_num   = ({32'd0, r_dr} * {32'd0, llm_pkg::US_PER_S}) << 8;
                n_op    = llm_pkg::OP_RATE;
                n_state = llm_pkg::ST_LOAD;
            end
            llm_pkg::ST_DECIDE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_level                = decided;
                    n_out.load_level       = decided;
                    n_out.level_changed    = (decided != r_level);
                    n_changes              = r_changes + ((decided != r_level) ? 32'd1 : 32'd0);
                    n_out.change_count     = n_changes;
                    n_out.smoothed_rate    = r_ravg;
                    n_out.smoothed_queue   = r_qavg;
                    n_out.smoothed_pending = r_pavg;
                    n_out.smoothed_ratio   = r_ratavg;
                    n_out_valid            = 1'b1;
                    n_state                = llm_pkg::ST_IDLE;
                end
            end
            default: n_state = llm_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= llm_pkg::ST_IDLE;
            r_op        <= llm_pkg::OP_QUEUE;
            r_eval      <= 1'b0;
            r_primed    <= 1'b0;
            r_prev_time <= 48'd0;
            r_prev_rx   <= 32'd0;
            r_prev_cx   <= 32'd0;
            r_qavg      <= 17'd0;
            r_pavg      <= 17'd0;
            r_ravg      <= 32'd0;
            r_ratavg    <= llm_pkg::ONE_Q16;
            r_level     <= llm_pkg::LVL_NORMAL;
            r_changes   <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_eval      <= n_eval;
            r_primed    <= n_primed;
            r_prev_time <= n_prev_time;
            r_prev_rx   <= n_prev_rx;
            r_prev_cx   <= n_prev_cx;
            r_qavg      <= n_qavg;
            r_pavg      <= n_pavg;
            r_ravg      <= n_ravg;
            r_ratavg    <= n_ratavg;
            r_level     <= n_level;
            r_changes   <= n_changes;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_smp    <= n_smp;
        r_dr     <= n_dr;
        r_dc     <= n_dc;
        r_el     <= n_el;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_sample <= n_sample;
        r_out    <= n_out;
    end

`ifndef SYNTHESIS
    // averages of fractions never pass 1.0
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qavg <= llm_pkg::ONE_Q16) && (r_pavg <= llm_pkg::ONE_Q16)
        && (r_ratavg <= llm_pkg::ONE_Q16))
        else $error("smoothed fraction above 1.0");

    // a held result carries the current change count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.change_count == r_changes))
        else $error("result change count out of step");

    // a new result only comes from the decision step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == llm_pkg::ST_DECIDE))
        else $error("result raised outside decision");

    // divider never leaves with a live count
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llm_pkg::ST_DIV && r_cnt != 6'd0) |=> (r_state == llm_pkg::ST_DIV))
        else $error("divider left early");
`endif

endmodule

>>> bench/load_level_monitor_tb.sv
// Testbench of the load level monitor: directed and random samples checked against a built-in predictor.
`timescale 1ns / 100ps
module load_level_monitor_tb;

    localparam int  N_RANDOM  = 1730;
    localparam int  N_PHASES  = 6;
    localparam int  LONG_HOLD = 600;
    localparam int  TAIL      = 200;
    localparam longint LIMIT  = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    llm_in_if  in_ch ();
    llm_out_if out_ch ();
    llm_cfg_if cfg_ch ();

    load_level_monitor u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    // stimulus and expectations
    llm_pkg::t_sample sample_q[$];
    llm_pkg::t_result expected_q[$];
    int      errors = 0;
    int      cfg_writes = 0;
    bit      in_fire = 1'b0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      long_stall = 1'b0;
    longint  cycles = 0;

    // predictor copy of registers and state
    logic [23:0] p_rate_high, p_rate_low;
    logic [16:0] p_queue_high, p_queue_low, p_pend_high, p_pend_low, p_ratio_low;
    logic [31:0] p_ratio_min;
    logic [31:0] avg_queue, avg_pend, avg_rate, avg_ratio;
    bit          seen_first;
    logic [47:0] last_time;
    logic [31:0] last_rx, last_cx;
    llm_pkg::t_level cur_level;
    logic [31:0] level_changes;

    // generator state for well-formed sample sequences
    logic [47:0] g_time = 48'd1000;
    logic [31:0] g_rx = 0, g_cx = 0;

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] ema(logic [31:0] prev, logic [31:0] smp);
        logic [63:0] acc;
        acc = 64'(prev) * 64'd43909 + 64'(smp) * 64'd21627 + 64'd32768;
        return acc[47:16];
    endfunction

    function automatic logic [31:0] q16_frac(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 0) return 32'd0;
        q = (num << 16) / den;
        return (q > 64'd65536) ? 32'd65536 : q[31:0];
    endfunction

    // predicted result of one accepted sample
    function automatic llm_pkg::t_result predict_sample(llm_pkg::t_sample s);
        llm_pkg::t_result r;
        llm_pkg::t_level prior;
        logic [63:0] el, dr, dc, rs;
        bit hi, lo, susp;
        r.level_changed = 1'b0;
        avg_queue = ema(avg_queue, q16_frac(64'(s.queue_used), 64'(s.queue_size)));
        avg_pend  = ema(avg_pend, q16_frac(64'(s.pending_used), 64'(s.pending_size)));
        if (!seen_first) begin
            seen_first = 1'b1;
            last_time = s.time_us;
            last_rx = s.received_total;
            last_cx = s.completed_total;
        end else begin
            prior = cur_level;
            if (s.time_us > last_time) begin
                el = 64'(s.time_us - last_time);
                dr = (s.received_total >= last_rx) ? 64'(s.received_total - last_rx) : 64'd0;
                dc = (s.completed_total >= last_cx) ? 64'(s.completed_total - last_cx) : 64'd0;
                rs = (dr * 64'd256000000) / el;
                if (rs > 64'hFFFF_FFFF) rs = 64'hFFFF_FFFF;
                avg_rate = ema(avg_rate, rs[31:0]);
                if (dr >= 64'(p_ratio_min))
                    avg_ratio = ema(avg_ratio, (dr == 0) ? 32'd65536 : q16_frac(dc, dr));
                last_time = s.time_us;
                last_rx = s.received_total;
                last_cx = s.completed_total;
            end
            susp = 64'(avg_rate) >= (64'(p_rate_low) << 8) && avg_ratio < 32'(p_ratio_low);
            hi = 64'(avg_rate) >= (64'(p_rate_high) << 8) || avg_queue >= 32'(p_queue_high)
                 || avg_pend >= 32'(p_pend_high);
            lo = 64'(avg_rate) <= (64'(p_rate_low) << 8) && avg_queue <= 32'(p_queue_low)
                 && avg_pend <= 32'(p_pend_low);
            if (hi || susp) cur_level = llm_pkg::LVL_OVER;
            else if (lo) cur_level = llm_pkg::LVL_NORMAL;
            else if (cur_level != llm_pkg::LVL_OVER) cur_level = llm_pkg::LVL_ELEVATED;
            if (cur_level != prior) begin
                level_changes++;
                r.level_changed = 1'b1;
            end
        end
        r.load_level = cur_level;
        r.change_count = level_changes;
        r.smoothed_rate = avg_rate;
        r.smoothed_queue = avg_queue[16:0];
        r.smoothed_pending = avg_pend[16:0];
        r.smoothed_ratio = avg_ratio[16:0];
        return r;
    endfunction

    // sample edge: check results, predict accepted samples, track register writes
    always @(posedge i_clk) begin
        llm_pkg::t_result w;
        cycles++;
        if (cycles > LIMIT) begin
            $display("[load_level_monitor] ERROR");
            $finish;
        end
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 64'd1, 64'd0);
            end else begin
                w = expected_q.pop_front();
                if (out_ch.data.load_level != w.load_level)
                    report("load_level", 64'(out_ch.data.load_level), 64'(w.load_level));
                if (out_ch.data.level_changed != w.level_changed)
                    report("level_changed", 64'(out_ch.data.level_changed),
                           64'(w.level_changed));
                if (out_ch.data.change_count != w.change_count)
                    report("change_count", 64'(out_ch.data.change_count),
                           64'(w.change_count));
                if (out_ch.data.smoothed_rate != w.smoothed_rate)
                    report("smoothed_rate", 64'(out_ch.data.smoothed_rate),
                           64'(w.smoothed_rate));
                if (out_ch.data.smoothed_queue != w.smoothed_queue)
                    report("smoothed_queue", 64'(out_ch.data.smoothed_queue),
                           64'(w.smoothed_queue));
                if (out_ch.data.smoothed_pending != w.smoothed_pending)
                    report("smoothed_pending", 64'(out_ch.data.smoothed_pending),
                           64'(w.smoothed_pending));
                if (out_ch.data.smoothed_ratio != w.smoothed_ratio)
                    report("smoothed_ratio", 64'(out_ch.data.smoothed_ratio),
                           64'(w.smoothed_ratio));
            end
        end
        if (in_fire) expected_q.push_back(predict_sample(in_ch.data));
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (llm_pkg::t_cfg_index'(cfg_ch.index))
                llm_pkg::CFG_RATE_HIGH:    p_rate_high = cfg_ch.data[23:0];
                llm_pkg::CFG_RATE_LOW:     p_rate_low = cfg_ch.data[23:0];
                llm_pkg::CFG_QUEUE_HIGH:   p_queue_high = cfg_ch.data[16:0];
                llm_pkg::CFG_QUEUE_LOW:    p_queue_low = cfg_ch.data[16:0];
                llm_pkg::CFG_PENDING_HIGH: p_pend_high = cfg_ch.data[16:0];
                llm_pkg::CFG_PENDING_LOW:  p_pend_low = cfg_ch.data[16:0];
                llm_pkg::CFG_RATIO_MIN:    p_ratio_min = cfg_ch.data;
                llm_pkg::CFG_RATIO_LOW:    p_ratio_low = cfg_ch.data[16:0];
                default: ;
            endcase
            cfg_writes++;
        end
    end

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
        end else if (!in_ch.valid || in_fire) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                in_ch.data <= sample_q.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off when requested
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (long_stall && !hold_done) begin
            out_ch.ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic wait_idle();
        while (sample_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
            @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(llm_pkg::t_cfg_index idx, logic [31:0] value);
        int n;
        n = cfg_writes;
        @(negedge i_clk);
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        cfg_ch.valid <= 1'b1;
        while (cfg_writes == n) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] rh, logic [23:0] rl, logic [16:0] qh,
                             logic [16:0] ql, logic [16:0] ph, logic [16:0] pl,
                             logic [31:0] rmin, logic [16:0] rlow);
        write_reg(llm_pkg::CFG_RATE_HIGH, 32'(rh));
        write_reg(llm_pkg::CFG_RATE_LOW, 32'(rl));
        write_reg(llm_pkg::CFG_QUEUE_HIGH, 32'(qh));
        write_reg(llm_pkg::CFG_QUEUE_LOW, 32'(ql));
        write_reg(llm_pkg::CFG_PENDING_HIGH, 32'(ph));
        write_reg(llm_pkg::CFG_PENDING_LOW, 32'(pl));
        write_reg(llm_pkg::CFG_RATIO_MIN, rmin);
        write_reg(llm_pkg::CFG_RATIO_LOW, 32'(rlow));
    endtask

    function automatic llm_pkg::t_sample mk(logic [15:0] qu, logic [15:0] qs,
                                            logic [15:0] pu, logic [15:0] ps,
                                            logic [31:0] rx, logic [31:0] cx,
                                            logic [47:0] t);
        llm_pkg::t_sample s;
        s.queue_used = qu; s.queue_size = qs;
        s.pending_used = pu; s.pending_size = ps;
        s.received_total = rx; s.completed_total = cx; s.time_us = t;
        return s;
    endfunction

    // next sample: mostly a plausible continuation, sometimes raw noise
    function automatic llm_pkg::t_sample next_sample();
        llm_pkg::t_sample s;
        logic [15:0] qs, ps;
        int dr;
        if ($urandom_range(99) < 12) begin
            s = mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   32'($urandom), 32'($urandom), {16'($urandom), 32'($urandom)});
        end else begin
            qs = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
            ps = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
            if ($urandom_range(9) != 0) g_time += 48'($urandom_range(1, 3000));
            dr = ($urandom_range(15) == 0) ? int'($urandom_range(0, 100000))
                                           : int'($urandom_range(0, 24));
            g_rx += 32'(dr);
            g_cx += 32'($urandom_range(0, dr));
            s = mk(16'($urandom_range(0, qs + 4)), qs, 16'($urandom_range(0, ps + 4)), ps,
                   g_rx, g_cx, g_time);
        end
        g_time = s.time_us; g_rx = s.received_total; g_cx = s.completed_total;
        return s;
    endfunction

    initial begin
        int per_phase;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        p_rate_high = 24'd1000; p_rate_low = 24'd200;
        p_queue_high = 17'd52429; p_queue_low = 17'd19661;
        p_pend_high = 17'd52429; p_pend_low = 17'd19661;
        p_ratio_min = 32'd16; p_ratio_low = 17'd32768;
        avg_queue = 0; avg_pend = 0; avg_rate = 0; avg_ratio = 32'd65536;
        seen_first = 1'b0; last_time = 0; last_rx = 0; last_cx = 0;
        cur_level = llm_pkg::LVL_NORMAL; level_changes = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: first sample, zero capacities, saturation, stalled time, backwards counters
        sample_q.push_back(mk(16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 48'd100));
        sample_q.push_back(mk(16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 32'd10, 32'd5, 48'd100));
        sample_q.push_back(mk(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 32'd40, 32'd40, 48'd101));
        sample_q.push_back(mk(16'd1, 16'hFFFF, 16'd3, 16'd4, 32'hFFFF_FFFF, 32'd0, 48'd102));
        sample_q.push_back(mk(16'd5, 16'd10, 16'd5, 16'd10, 32'd3, 32'd3, 48'd200));
        sample_q.push_back(mk(16'd0, 16'd8, 16'd0, 16'd8, 32'd3, 32'd3, 48'd150));
        sample_q.push_back(mk(16'd0, 16'd8, 16'd0, 16'd8, 32'd100, 32'd20, 48'd1200));
        sample_q.push_back(mk(16'd0, 16'd8, 16'd0, 16'd8, 32'd200, 32'd60, 48'd1300));
        sample_q.push_back(mk(16'd0, 16'd8, 16'd0, 16'd8, 32'd200, 32'd60, 48'h1000000));
        sample_q.push_back(mk(16'd0, 16'd8, 16'd0, 16'd8, 32'd210, 32'd300,
                              48'hFFFF_FFFF_FFFF));
        sample_q.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        wait_idle();
        // zero minimum received: ratio sample with nothing received
        write_reg(llm_pkg::CFG_RATIO_MIN, 32'd0);
        sample_q.push_back(mk(16'd2, 16'd4, 16'd2, 16'd4, 32'd5, 32'd5, 48'd10));
        sample_q.push_back(mk(16'd2, 16'd4, 16'd2, 16'd4, 32'd5, 32'd5, 48'd20));
        sample_q.push_back(mk(16'd2, 16'd4, 16'd2, 16'd4, 32'd9, 32'd1, 48'd30));
        sample_q.push_back(mk(16'd2, 16'd4, 16'd2, 16'd4, 32'd9, 32'd1, 48'd30));
        g_time = 48'd30; g_rx = 32'd9; g_cx = 32'd1;

        per_phase = N_RANDOM / N_PHASES;
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            idle_pct = 0;
            stall_pct = 0;
            case (p)
                0: write_all(24'd1000, 24'd200, 17'd52429, 17'd19661, 17'd52429, 17'd19661,
                             32'd16, 17'd32768);
                1: write_all(24'hFFFFFF, 24'hFFFFFF, 17'd65536, 17'd65536, 17'd65536,
                             17'd65536, 32'hFFFF_FFFF, 17'd65536);
                2: write_all(24'd0, 24'd0, 17'd0, 17'd0, 17'd0, 17'd0, 32'd0, 17'd0);
                default: write_all(24'($urandom_range(100, 20000)),
                                   24'($urandom_range(0, 3000)),
                                   17'($urandom_range(20000, 65536)),
                                   17'($urandom_range(0, 30000)),
                                   17'($urandom_range(20000, 65536)),
                                   17'($urandom_range(0, 30000)),
                                   32'($urandom_range(0, 40)),
                                   17'($urandom_range(0, 65536)));
            endcase
            case (p % 4)
                1: idle_pct = 60;
                2: stall_pct = 60;
                3: begin idle_pct = 26; stall_pct = 26; end
                default: ;
            endcase
            if (p == 4) long_stall = 1'b1;
            for (int k = 0; k < per_phase; k++) sample_q.push_back(next_sample());
        end

        wait_idle();
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0)
            $display("[load_level_monitor] OK");
        else
            $display("[load_level_monitor] ERROR");
        $finish;
    end
endmodule

>>> files.f
sv/llm_pkg.sv
sv/llm_if.sv
sv/load_level_monitor.sv
bench/load_level_monitor_tb.sv
